FILE: design/pcvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcvc_pkg
// Shared types and constants of the pixel color vote classifier.
// ----------------------------------------------------------------------------
package pcvc_pkg;

  localparam int PIX_W       = 8;
  localparam int MIN_W       = 13;
  localparam int WIN_W       = 13;
  localparam int CLS_W       = 3;
  localparam int NUM_CLASSES = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  typedef logic [CLS_W-1:0] class_t;
  typedef logic [PIX_W-1:0] chan_t;
  typedef logic [MIN_W-1:0] min_votes_t;
  typedef logic [WIN_W-1:0] win_count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam class_t CLS_BLACK   = 3'd0;
  localparam class_t CLS_RED     = 3'd1;
  localparam class_t CLS_GREEN   = 3'd2;
  localparam class_t CLS_BLUE    = 3'd3;
  localparam class_t CLS_YELLOW  = 3'd4;
  localparam class_t CLS_PURPLE  = 3'd5;
  localparam class_t CLS_GRAY    = 3'd6;
  localparam class_t CLS_UNKNOWN = 3'd7;

  localparam cfg_idx_t CFG_UNKNOWN_MIN = 2'd0;
  localparam cfg_idx_t CFG_BLACK_LEVEL = 2'd1;

  localparam min_votes_t RST_UNKNOWN_MIN = 13'd6;
  localparam chan_t      RST_BLACK_LEVEL = 8'd100;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last_pixel;
  } pixel_t;

  // Classified pixel handed from the classify stage to the tally stage.
  typedef struct packed {
    logic   valid;
    class_t cls;
    logic   last;
  } cls_req_t;

endpackage

FILE: design/pixel_color_vote_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_color_vote_classifier_core
// Streams the pixels of an image tile, votes a color class per pixel and
// reports the winning class when the tile ends.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one RGB pixel per request, in_last_pixel marks the
//   final pixel of a tile. Result channel (out_*): one request per tile with
//   the winning class and the best non-unknown count; other pixels give none.
//   Throughput: one pixel per clock while in_stall is low, back to back
//   across tile boundaries. A tile's last pixel passes the input register,
//   classify, tally/snapshot and black adjust stages into the result register.
//   When the receiver stalls, the result register holds, the adjust stage and
//   the end-of-tile snapshot fill behind it; pixels keep flowing into the
//   counters of the next tile, and in_stall rises only when a further last
//   pixel would find no free snapshot slot.
//   Reset (rst_n low, synchronous) empties the pipe, clears all vote
//   counters and loads unknown_min_votes = 6 and black_level = 100.
//   Configuration: write cfg_wdata to register cfg_index with cfg_we, only
//   while the block is idle. Index 0: unknown_min_votes, 1: black_level.
// ----------------------------------------------------------------------------
module pixel_color_vote_classifier_core #(
  parameter int MAX_PIXELS = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // pixel requests
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pcvc_pkg::chan_t             in_red,
  input  pcvc_pkg::chan_t             in_green,
  input  pcvc_pkg::chan_t             in_blue,
  input  logic                        in_last_pixel,
  // result requests
  output logic                        out_valid,
  input  logic                        out_stall,
  output pcvc_pkg::class_t            out_color_class,
  output pcvc_pkg::win_count_t        out_winning_count,
  // configuration writes
  input  logic                        cfg_we,
  input  pcvc_pkg::cfg_idx_t          cfg_index,
  input  logic [pcvc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pcvc_pkg::*;

  // Counters must hold MAX_PIXELS itself.
  localparam int CNT_W = $clog2(MAX_PIXELS + 1);

  logic             pipe_go;
  logic             pix_valid_r;
  pixel_t           pix_r;
  cls_req_t         cls_req;
  min_votes_t       unknown_min_r;
  chan_t            black_level_r;
  logic             vote_ready;
  logic             snap_valid;
  logic [CNT_W-1:0] snap_votes [NUM_CLASSES];
  logic [CNT_W-1:0] snap_total;

  // Back-pressure only comes from a blocked end-of-tile snapshot.
  assign in_stall = !pipe_go;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unknown_min_r <= RST_UNKNOWN_MIN;
      black_level_r <= RST_BLACK_LEVEL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UNKNOWN_MIN: unknown_min_r <= MIN_W'(cfg_wdata);
        CFG_BLACK_LEVEL: black_level_r <= PIX_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Input register: advance with the rest of the front pipe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
    end else if (pipe_go) begin
      pix_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_go) begin
      pix_r.red        <= in_red;
      pix_r.green      <= in_green;
      pix_r.blue       <= in_blue;
      pix_r.last_pixel <= in_last_pixel;
    end
  end

  pcvc_classify u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .pipe_go     (pipe_go),
    .pix_valid   (pix_valid_r),
    .pix         (pix_r),
    .black_level (black_level_r),
    .cls_req     (cls_req)
  );

  pcvc_tally #(
    .CNT_W      (CNT_W),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_tally (
    .clk        (clk),
    .rst_n      (rst_n),
    .cls_req    (cls_req),
    .vote_ready (vote_ready),
    .pipe_go    (pipe_go),
    .snap_valid (snap_valid),
    .snap_votes (snap_votes),
    .snap_total (snap_total)
  );

  pcvc_vote #(
    .CNT_W (CNT_W)
  ) u_vote (
    .clk               (clk),
    .rst_n             (rst_n),
    .snap_valid        (snap_valid),
    .snap_votes        (snap_votes),
    .snap_total        (snap_total),
    .unknown_min       (unknown_min_r),
    .out_stall         (out_stall),
    .vote_ready        (vote_ready),
    .out_valid         (out_valid),
    .out_color_class   (out_color_class),
    .out_winning_count (out_winning_count)
  );

endmodule

FILE: design/pcvc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcvc_classify
// Threshold rules that map one RGB pixel to a color class, registered.
// ----------------------------------------------------------------------------
module pcvc_classify (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pipe_go,
  input  logic              pix_valid,
  input  pcvc_pkg::pixel_t  pix,
  input  pcvc_pkg::chan_t   black_level,
  output pcvc_pkg::cls_req_t cls_req
);
  import pcvc_pkg::*;

  localparam chan_t GREEN_MIN   = 8'd120;
  localparam chan_t GREEN_LEAD  = 8'd30;
  localparam chan_t RB_LEAD     = 8'd5;
  localparam chan_t HUE_LEAD    = 8'd40;
  localparam chan_t RED_MIN     = 8'd200;
  localparam chan_t GRAY_SPREAD = 8'd14;

  // a > b + k without wrap
  function automatic logic gt_plus(input chan_t a, input chan_t b, input chan_t k);
    return {1'b0, a} > ({1'b0, b} + {1'b0, k});
  endfunction

  function automatic chan_t absdiff(input chan_t a, input chan_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  class_t   cls_nxt;
  cls_req_t req_r;

  always_comb begin
    if (pix.red < black_level && pix.green < black_level && pix.blue < black_level) begin
      cls_nxt = CLS_BLACK;
    end else if (pix.green > GREEN_MIN && gt_plus(pix.green, pix.red, GREEN_LEAD) &&
                 gt_plus(pix.red, pix.blue, RB_LEAD)) begin
      cls_nxt = CLS_GREEN;
    end else if (gt_plus(pix.blue, pix.green, HUE_LEAD) &&
                 gt_plus(pix.green, pix.red, HUE_LEAD)) begin
      cls_nxt = CLS_BLUE;
    end else if (absdiff(pix.blue, pix.red) < HUE_LEAD &&
                 gt_plus(pix.red, pix.green, HUE_LEAD)) begin
      cls_nxt = CLS_PURPLE;
    end else if (pix.red > RED_MIN && gt_plus(pix.red, pix.green, HUE_LEAD) &&
                 absdiff(pix.green, pix.blue) < HUE_LEAD) begin
      cls_nxt = CLS_RED;
    end else if (pix.red > RED_MIN && gt_plus(pix.green, pix.blue, HUE_LEAD)) begin
      cls_nxt = CLS_YELLOW;
    end else if (absdiff(pix.red, pix.green) < GRAY_SPREAD &&
                 absdiff(pix.blue, pix.red) < GRAY_SPREAD &&
                 absdiff(pix.green, pix.blue) < GRAY_SPREAD) begin
      cls_nxt = CLS_GRAY;
    end else begin
      cls_nxt = CLS_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= '0;
    end else if (pipe_go) begin
      req_r.valid <= pix_valid;
      req_r.cls   <= cls_nxt;
      req_r.last  <= pix.last_pixel;
    end
  end

  assign cls_req = req_r;

endmodule

FILE: design/pcvc_tally.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcvc_tally
// Saturating per-class vote counters; snapshot of the tally at end of tile.
// ----------------------------------------------------------------------------
module pcvc_tally #(
  parameter int CNT_W      = 13,
  parameter int MAX_PIXELS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pcvc_pkg::cls_req_t cls_req,
  input  logic               vote_ready,
  output logic               pipe_go,
  output logic               snap_valid,
  output logic [CNT_W-1:0]   snap_votes [pcvc_pkg::NUM_CLASSES],
  output logic [CNT_W-1:0]   snap_total
);
  import pcvc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

  logic [CNT_W-1:0] votes_r   [NUM_CLASSES];
  logic [CNT_W-1:0] votes_inc [NUM_CLASSES];
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] total_inc;
  logic [CNT_W-1:0] snap_votes_r [NUM_CLASSES];
  logic [CNT_W-1:0] snap_total_r;
  logic             snap_valid_r;
  logic             snap_valid_nxt;
  logic             snap_free;
  logic             upd;
  logic             tile_end;

  // A finished tile can only leave when the snapshot slot is free; hold the
  // front of the pipe otherwise.
  assign snap_free = !snap_valid_r || vote_ready;
  assign pipe_go   = !(cls_req.valid && cls_req.last && !snap_free);
  assign upd       = pipe_go && cls_req.valid;
  assign tile_end  = upd && cls_req.last;

  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      votes_inc[i] = votes_r[i];
      if (cls_req.cls == class_t'(i) && votes_r[i] < CNT_MAX) begin
        votes_inc[i] = votes_r[i] + 1'b1;
      end
    end
    total_inc = (total_r < CNT_MAX) ? (total_r + 1'b1) : total_r;
  end

  always_comb begin
    snap_valid_nxt = snap_valid_r;
    if (tile_end) begin
      snap_valid_nxt = 1'b1;
    end else if (vote_ready) begin
      snap_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        votes_r[i] <= '0;
      end
      total_r      <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      snap_valid_r <= snap_valid_nxt;
      if (upd) begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
          votes_r[i] <= cls_req.last ? '0 : votes_inc[i];
        end
        total_r <= cls_req.last ? '0 : total_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tile_end) begin
      snap_votes_r <= votes_inc;
      snap_total_r <= total_inc;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap_votes = snap_votes_r;
  assign snap_total = snap_total_r;

endmodule

FILE: design/pcvc_vote.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcvc_vote
// Black-majority adjust, winner pick with unknown re-vote, result register.
// ----------------------------------------------------------------------------
module pcvc_vote #(
  parameter int CNT_W = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 snap_valid,
  input  logic [CNT_W-1:0]     snap_votes [pcvc_pkg::NUM_CLASSES],
  input  logic [CNT_W-1:0]     snap_total,
  input  pcvc_pkg::min_votes_t unknown_min,
  input  logic                 out_stall,
  output logic                 vote_ready,
  output logic                 out_valid,
  output pcvc_pkg::class_t     out_color_class,
  output pcvc_pkg::win_count_t out_winning_count
);
  import pcvc_pkg::*;

  localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;

  logic [CNT_W-1:0] adj_votes_r   [NUM_CLASSES];
  logic [CNT_W-1:0] adj_votes_nxt [NUM_CLASSES];
  logic             adj_valid_r;
  logic             adj_free;
  logic             out_free;
  logic             out_valid_r;
  class_t           color_r;
  win_count_t       count_r;
  logic [CNT_W-1:0] best;
  class_t           best_idx;
  class_t           win_nxt;

  assign out_free   = !out_valid_r || !out_stall;
  assign adj_free   = !adj_valid_r || out_free;
  assign vote_ready = adj_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_valid_r <= 1'b0;
    end else if (adj_free) begin
      adj_valid_r <= snap_valid;
    end
  end

  // Black keeps the whole tile on a strict majority, else drops out.
  always_comb begin
    adj_votes_nxt = snap_votes;
    adj_votes_nxt[CLS_BLACK] =
      ({snap_votes[CLS_BLACK], 1'b0} > {1'b0, snap_total}) ? snap_total : '0;
  end

  always_ff @(posedge clk) begin
    if (adj_free && snap_valid) begin
      adj_votes_r <= adj_votes_nxt;
    end
  end

  // Best of all classes but unknown; lowest index wins ties.
  always_comb begin
    best     = adj_votes_r[0];
    best_idx = CLS_BLACK;
    for (int i = 1; i < NUM_CLASSES - 1; i++) begin
      if (adj_votes_r[i] > best) begin
        best     = adj_votes_r[i];
        best_idx = class_t'(i);
      end
    end
  end

  // Unknown takes the first vote only when strictly ahead; then the runner-up
  // must reach the minimum or the answer is still unknown.
  always_comb begin
    win_nxt = best_idx;
    if (adj_votes_r[CLS_UNKNOWN] > best && CMP_W'(best) < CMP_W'(unknown_min)) begin
      win_nxt = CLS_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= adj_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && adj_valid_r) begin
      color_r <= win_nxt;
      count_r <= WIN_W'(best);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_color_class   = color_r;
  assign out_winning_count = count_r;

endmodule
